// ----- design/binary_to_decimal_ascii_core_assert.svh -----
// assertion macros for the binary to decimal ascii core
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// property must hold at every clock edge out of reset
`define BDAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define BDAC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- design/bdac_pkg.sv -----
package bdac_pkg;

  localparam int BinWidth   = 32;
  localparam int DigitCount = 10;
  localparam int NibWidth   = 4;
  localparam int BcdWidth   = DigitCount * NibWidth;
  localparam int AsciiWidth = 6;
  localparam int CountWidth = 4;

  localparam logic [AsciiWidth-1:0] AsciiZero = 6'd48;
  localparam logic [CountWidth-1:0] ZeroCap   = 4'd9;
  localparam logic [NibWidth-1:0]   AdjLimit  = 4'd5;
  localparam logic [NibWidth-1:0]   AdjAdd    = 4'd3;

  // one stage of the shift-and-add-3 chain
  typedef struct packed {
    logic                valid;
    logic [BcdWidth-1:0] bcd;
    logic [BinWidth-1:0] bin;
  } cell_t;

  typedef logic [DigitCount-1:0][AsciiWidth-1:0] ascii_row_t;

endpackage

// ----- design/bdac_if.sv -----
// input word channel
interface bdac_in_if import bdac_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BinWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// result word channel
interface bdac_out_if import bdac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [AsciiWidth-1:0] ascii_digit_0;
  logic [AsciiWidth-1:0] ascii_digit_1;
  logic [AsciiWidth-1:0] ascii_digit_2;
  logic [AsciiWidth-1:0] ascii_digit_3;
  logic [AsciiWidth-1:0] ascii_digit_4;
  logic [AsciiWidth-1:0] ascii_digit_5;
  logic [AsciiWidth-1:0] ascii_digit_6;
  logic [AsciiWidth-1:0] ascii_digit_7;
  logic [AsciiWidth-1:0] ascii_digit_8;
  logic [AsciiWidth-1:0] ascii_digit_9;
  logic [CountWidth-1:0] leading_zero_count;

  modport source (
    output valid, input ready,
    output ascii_digit_0, output ascii_digit_1, output ascii_digit_2,
    output ascii_digit_3, output ascii_digit_4, output ascii_digit_5,
    output ascii_digit_6, output ascii_digit_7, output ascii_digit_8,
    output ascii_digit_9, output leading_zero_count
  );
  modport sink (
    input valid, output ready,
    input ascii_digit_0, input ascii_digit_1, input ascii_digit_2,
    input ascii_digit_3, input ascii_digit_4, input ascii_digit_5,
    input ascii_digit_6, input ascii_digit_7, input ascii_digit_8,
    input ascii_digit_9, input leading_zero_count
  );
endinterface

// ----- design/binary_to_decimal_ascii_core.sv -----
// Converts an unsigned 32-bit word to ten ASCII decimal digits, billions place
// first with leading zeros kept, plus the number of leading zero digits capped
// at 9. One word is accepted per clock cycle while the output is not stalled.
// The conversion is a chain of 32 registered shift-and-add-3 cells, one input
// bit per cell, and a result is offered from the last cell. A stalled output
// holds the whole chain; it moves when the output register is empty or being taken.
module binary_to_decimal_ascii_core import bdac_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  bdac_in_if.sink    in_word,
  bdac_out_if.source out_word
);

`include "binary_to_decimal_ascii_core_assert.svh"

  cell_t           chain [BinWidth+1];
  logic            adv;
  logic            tail_move;
  ascii_row_t      ascii;
  logic [CountWidth-1:0] zero_cnt;

  // chain advances when the last cell is free or its word is taken
  assign adv           = !chain[BinWidth].valid || out_word.ready;
  assign in_word.ready = adv;

  assign chain[0].valid = in_word.valid;
  assign chain[0].bcd   = '0;
  assign chain[0].bin   = in_word.value;

  // one cell per input bit
  for (genvar i = 0; i < BinWidth; i++) begin : g_cell
    bdac_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // ascii digits and zero count from the last cell
  bdac_fmt u_fmt (
    .bcd_i      (chain[BinWidth].bcd),
    .ascii_o    (ascii),
    .zero_cnt_o (zero_cnt)
  );

  assign out_word.valid              = chain[BinWidth].valid;
  assign out_word.ascii_digit_0      = ascii[0];
  assign out_word.ascii_digit_1      = ascii[1];
  assign out_word.ascii_digit_2      = ascii[2];
  assign out_word.ascii_digit_3      = ascii[3];
  assign out_word.ascii_digit_4      = ascii[4];
  assign out_word.ascii_digit_5      = ascii[5];
  assign out_word.ascii_digit_6      = ascii[6];
  assign out_word.ascii_digit_7      = ascii[7];
  assign out_word.ascii_digit_8      = ascii[8];
  assign out_word.ascii_digit_9      = ascii[9];
  assign out_word.leading_zero_count = zero_cnt;

  // a word moving out of the next to last cell
  assign tail_move = adv && chain[BinWidth-1].valid;

  // checks
  `BDAC_ASSERT(a_tail_fill, $past(tail_move) |-> out_word.valid, "word lost at chain end")
  `BDAC_ASSERT(a_empty_takes, !out_word.valid |-> in_word.ready, "input blocked while empty")
  `BDAC_NEVER(a_top_digit, out_word.valid && ascii[0] > AsciiZero + 6'd4, "billions above 4")
  `BDAC_NEVER(a_units_digit, out_word.valid && ascii[9] > AsciiZero + 6'd9, "units not decimal")

endmodule

// ----- design/bdac_cell.sv -----
module bdac_cell import bdac_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t cell_i,
  output cell_t cell_o
);

  logic [BcdWidth-1:0] adj;
  cell_t               cell_nxt;
  cell_t               cell_r;

  // add 3 to every digit of 5 or more, then shift in the next binary bit
  always_comb begin
    adj = cell_i.bcd;
    for (int n = 0; n < DigitCount; n++) begin
      if (cell_i.bcd[n*NibWidth +: NibWidth] >= AdjLimit) begin
        adj[n*NibWidth +: NibWidth] = cell_i.bcd[n*NibWidth +: NibWidth] + AdjAdd;
      end
    end
    cell_nxt.valid = cell_i.valid;
    cell_nxt.bcd   = {adj[BcdWidth-2:0], cell_i.bin[BinWidth-1]};
    cell_nxt.bin   = {cell_i.bin[BinWidth-2:0], 1'b0};
  end

  // valid flag under reset, payload only on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (en) begin
      cell_r.bcd <= cell_nxt.bcd;
      cell_r.bin <= cell_nxt.bin;
    end
  end

  assign cell_o = cell_r;

endmodule

// ----- design/bdac_fmt.sv -----
module bdac_fmt import bdac_pkg::*; (
  input  logic [BcdWidth-1:0]   bcd_i,
  output ascii_row_t            ascii_o,
  output logic [CountWidth-1:0] zero_cnt_o
);

  // digit 0 is the most significant nibble
  always_comb begin
    for (int k = 0; k < DigitCount; k++) begin
      ascii_o[k] = AsciiZero
        + {2'b00, bcd_i[(DigitCount-1-k)*NibWidth +: NibWidth]};
    end
  end

  // index of the first nonzero digit, units digit always shown
  always_comb begin
    zero_cnt_o = ZeroCap;
    for (int k = DigitCount-2; k >= 0; k--) begin
      if (bcd_i[(DigitCount-1-k)*NibWidth +: NibWidth] != '0) begin
        zero_cnt_o = CountWidth'(k);
      end
    end
  end

endmodule

// ----- tb/tb_binary_to_decimal_ascii_core.sv -----
module tb_binary_to_decimal_ascii_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bdac_pkg::*;

  localparam int unsigned TopPlace    = 1000000000;
  localparam int unsigned Radix       = 10;
  localparam int          ResetCycles = 12;
  localparam int          RandomWords = 1400;
  localparam int          LongHold    = 150;
  localparam int          SettleLimit = 40;
  localparam int          ReportLimit = 10;

  // expected conversion of one word
  typedef struct packed {
    ascii_row_t            digits;
    logic [CountWidth-1:0] zeros;
  } decimal_t;

  // one pending input word with its lead-in gap
  typedef struct {
    logic [BinWidth-1:0] value;
    int unsigned         gap;
    bit                  drain_first;
  } word_item_t;

  logic clk;
  logic rst_n;

  bdac_in_if  in_word ();
  bdac_out_if out_word ();

  word_item_t  pending_words[$];
  decimal_t    conversions_due[$];
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned mismatches;
  logic [DigitCount-1:0] zeros_seen;

  binary_to_decimal_ascii_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // decimal digits, billions place first, with the leading zero count
  function automatic decimal_t to_decimal(logic [BinWidth-1:0] value);
    decimal_t    res;
    int unsigned rest;
    int unsigned place;
    int unsigned digit;
    int unsigned zeros;
    bit          seen;
    rest  = value;
    place = TopPlace;
    zeros = 0;
    seen  = 1'b0;
    for (int k = 0; k < DigitCount; k++) begin
      digit = rest / place;
      rest  = rest - digit * place;
      if (digit == 0 && !seen) begin
        zeros++;
      end else begin
        seen = 1'b1;
      end
      res.digits[k] = AsciiZero + AsciiWidth'(digit);
      place = place / Radix;
    end
    res.zeros = (zeros > ZeroCap) ? ZeroCap : CountWidth'(zeros);
    return res;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // random value biased over the number of decimal digits
  function automatic logic [BinWidth-1:0] random_value();
    int unsigned len;
    int unsigned place;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(0, 3) == 0) return $urandom;
    len   = $urandom_range(1, DigitCount);
    place = 1;
    repeat (len - 1) place = place * Radix;
    lo = (len == 1) ? 0 : place;
    hi = (len == DigitCount) ? 32'hFFFF_FFFF : place * Radix - 1;
    return $urandom_range(hi, lo);
  endfunction

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("mismatch at word %0d, %s: expected %0d, got %0d",
               words_checked, field, want, got);
    end
  endtask

  // clock and known input levels from time zero
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_word.valid  = 1'b0;
    in_word.value  = '0;
    out_word.ready = 1'b0;
    forever #10 clk = ~clk;
  end

  // word driver: offers queued words, honoring gaps and drain requests
  always @(posedge clk) begin : word_driver
    word_item_t head;
    if (!rst_n) begin
      in_word.valid <= 1'b0;
      in_word.value <= '0;
    end else begin
      if (in_word.valid && in_word.ready) begin
        conversions_due.push_back(to_decimal(in_word.value));
        words_sent++;
      end
      if (!in_word.valid || in_word.ready) begin
        if (pending_words.size() == 0) begin
          in_word.valid <= 1'b0;
        end else if (pending_words[0].gap > 0) begin
          head = pending_words[0];
          head.gap--;
          pending_words[0] = head;
          in_word.valid <= 1'b0;
        end else if (pending_words[0].drain_first && conversions_due.size() != 0) begin
          in_word.valid <= 1'b0;
        end else begin
          head = pending_words.pop_front();
          in_word.valid <= 1'b1;
          in_word.value <= head.value;
        end
      end
    end
  end

  // result monitor: checks each word and paces ready
  int unsigned stall_left;

  always @(posedge clk) begin : result_monitor
    decimal_t want;
    decimal_t got;
    if (!rst_n) begin
      out_word.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_word.valid && out_word.ready) begin
        got.digits[0] = out_word.ascii_digit_0;
        got.digits[1] = out_word.ascii_digit_1;
        got.digits[2] = out_word.ascii_digit_2;
        got.digits[3] = out_word.ascii_digit_3;
        got.digits[4] = out_word.ascii_digit_4;
        got.digits[5] = out_word.ascii_digit_5;
        got.digits[6] = out_word.ascii_digit_6;
        got.digits[7] = out_word.ascii_digit_7;
        got.digits[8] = out_word.ascii_digit_8;
        got.digits[9] = out_word.ascii_digit_9;
        got.zeros     = out_word.leading_zero_count;
        if (conversions_due.size() == 0) begin
          report_mismatch("unexpected word, leading_zero_count", 0, got.zeros);
        end else begin
          want = conversions_due.pop_front();
          for (int k = 0; k < DigitCount; k++) begin
            if (got.digits[k] !== want.digits[k]) begin
              report_mismatch($sformatf("ascii_digit_%0d", k), want.digits[k], got.digits[k]);
            end
          end
          if (got.zeros !== want.zeros) begin
            report_mismatch("leading_zero_count", want.zeros, got.zeros);
          end
          zeros_seen[want.zeros] = 1'b1;
          words_checked++;
          // long hold so the chain fills and backs up the input
          if (words_checked == 200 || words_checked == 1000) begin
            stall_left = LongHold;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_word.ready <= 1'b0;
      end else begin
        out_word.ready <= 1'b1;
        // steady window with no receiver stalls
        if (!(words_checked >= 400 && words_checked < 550)) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    logic [BinWidth-1:0] directed_values[$];
    word_item_t          item;
    directed_values = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd9999, 32'd10000,
      32'd999999, 32'd1000000, 32'd99999999, 32'd100000000, 32'd999999999,
      32'd1000000000, 32'd1999999999, 32'd3999999999, 32'd4000000000,
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
      32'hAAAA_AAAA, 32'h5555_5555
    };
    zeros_seen = '0;
    // extremes, each digit count and alternating bit patterns
    foreach (directed_values[i]) begin
      item.value       = directed_values[i];
      item.gap         = 0;
      item.drain_first = 1'b0;
      pending_words.push_back(item);
    end
    // random words, with gap-free windows and periodic drains
    for (int i = 0; i < RandomWords; i++) begin
      item.value       = random_value();
      item.gap         = ((i >= 600 && i < 700) || (i >= 1100 && i < 1200)) ? 0 : pick_gap();
      item.drain_first = (i % 400 == 0);
      pending_words.push_back(item);
    end

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_word.valid) @(posedge clk);
    while (conversions_due.size() != 0) @(posedge clk);
    repeat (SettleLimit) @(posedge clk);

    $display("converted and checked %0d of %0d words, %0d mismatches",
             words_checked, words_sent, mismatches);
    $display("leading zero counts seen: %0d of %0d, with long output holds and drains",
             $countones(zeros_seen), DigitCount);
    if (mismatches == 0 && words_checked == words_sent) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #15_000_000;
    $display("timeout: %0d words sent, %0d checked", words_sent, words_checked);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- binary_to_decimal_ascii_core.f -----
+incdir+design
design/bdac_pkg.sv
design/bdac_if.sv
design/bdac_cell.sv
design/bdac_fmt.sv
design/binary_to_decimal_ascii_core.sv
tb/tb_binary_to_decimal_ascii_core.sv
